// ===== rtl/core/packet_deframer_crc16_assert.svh =====
// ---------------------------------------------------------------------------
// packet_deframer_crc16_assert.svh
// Assertion macros shared by the deframer modules (clk / rst_n domain).
// ---------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_CRC16_ASSERT_SVH
`define PACKET_DEFRAMER_CRC16_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pdc_pkg.sv =====
// ---------------------------------------------------------------------------
// pdc_pkg
// Types, codes and the byte-wise CRC16-CCITT update for the deframer.
// ---------------------------------------------------------------------------
package pdc_pkg;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_RW   = 3'd1,
    PH_CMD  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CRC  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA = 3'd0,
    K_GOOD = 3'd1,
    K_BAD  = 3'd2,
    K_LEN  = 3'd3,
    K_TIME = 3'd4
  } kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_READ_CODE    = 2'd0;
  localparam logic [1:0] REG_WRITE_CODE   = 2'd1;
  localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;
  localparam logic [1:0] REG_RX_TIMEOUT   = 2'd3;

  localparam logic [7:0]  SYNC_A   = 8'h55;
  localparam logic [7:0]  SYNC_B   = 8'hAA;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  TICK_MAX = 8'hFF;

  localparam logic [7:0]  RST_READ_CODE    = 8'd0;
  localparam logic [7:0]  RST_WRITE_CODE   = 8'd1;
  localparam logic [15:0] RST_LENGTH_LIMIT = 16'd540;
  localparam logic [7:0]  RST_RX_TIMEOUT   = 8'd50;

  typedef struct packed {
    logic [7:0]  read_code;
    logic [7:0]  write_code;
    logic [15:0] length_limit;
    logic [7:0]  rx_timeout;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  rw_flag;
    logic [15:0] command;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } result_t;

  // CRC16-CCITT, poly 0x1021, MSB first, one byte per call
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = {c[7:0], c[15:8]} ^ {8'h00, b};
    x = x ^ {12'h000, x[7:4]};
    x = x ^ {x[3:0], 12'h000};
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

  // CRC after the sync pair
  localparam logic [15:0] CRC_SYNC = crc_step(crc_step(CRC_INIT, SYNC_A), SYNC_B);

endpackage

// ===== rtl/core/packet_deframer_crc16.sv =====
// ---------------------------------------------------------------------------
// packet_deframer_crc16
// Sync-headed serial frame deframer with CRC16-CCITT check.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per received byte (in_tuser = 0) or timer tick
//           (in_tuser = 1). Frames are 0x55 0xAA, rw byte, command LE16,
//           length LE16, payload, CRC LE16 (CCITT, init 0xFFFF, over sync
//           through last payload byte).
//   out_* : at most one result per input beat: each payload byte, a CRC
//           good/bad report at frame end, a length abort or a tick timeout.
//           Beats that produce nothing are absorbed silently.
//   cfg_* : single-cycle register writes, only while the block is idle.
// Flow: an input beat is registered, then parsed in one pass into the
//   output register when it is free; a loaded result raises out_tvalid.
//   One beat per cycle is sustained while out_tready is high; the byte-wise
//   CRC XOR network and the length compare sit in that single parse stage.
// Reset (synchronous, rst_n low): configuration registers return to their
//   defaults, the parser hunts for sync and the output register empties.
// Stall: while out_tready is low a waiting result holds; one more input beat
//   is buffered, then in_tready drops until the result is taken.
// ---------------------------------------------------------------------------
module packet_deframer_crc16
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] rw_flag, [23:8] command,
                                  // [39:24] length, [47:40] data_byte
  output logic [2:0]  out_tuser,  // [2:0] kind
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  cfg_t    cfg_r;
  item_t   in_item;
  item_t   stg_item;
  logic    stg_valid;
  logic    out_free;
  logic    proc_fire;
  logic    res_valid;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;

  assign in_item.req_type = in_tuser;
  assign in_item.rx_byte  = in_tdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_code    <= RST_READ_CODE;
      cfg_r.write_code   <= RST_WRITE_CODE;
      cfg_r.length_limit <= RST_LENGTH_LIMIT;
      cfg_r.rx_timeout   <= RST_RX_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_READ_CODE:    cfg_r.read_code    <= cfg_wdata[7:0];
        REG_WRITE_CODE:   cfg_r.write_code   <= cfg_wdata[7:0];
        REG_LENGTH_LIMIT: cfg_r.length_limit <= cfg_wdata;
        REG_RX_TIMEOUT:   cfg_r.rx_timeout   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // parse stage advances whenever the output register can take its result
  assign out_free  = !out_valid_r || out_tready;
  assign proc_fire = stg_valid && out_free;

  pdc_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_item  (in_item),
    .m_valid (stg_valid),
    .m_take  (out_free),
    .m_item  (stg_item)
  );

  pdc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (proc_fire),
    .item      (stg_item),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = proc_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {out_r.data_byte, out_r.length, out_r.command, out_r.rw_flag};

endmodule

// ===== rtl/core/pdc_in_stage.sv =====
// ---------------------------------------------------------------------------
// pdc_in_stage
// Input register: holds one beat until the parser stage takes it.
// ---------------------------------------------------------------------------
module pdc_in_stage
  import pdc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  output logic  m_valid,
  input  logic  m_take,
  output item_t m_item
);

`include "packet_deframer_crc16_assert.svh"

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign s_ready = !valid_r || m_take;
  assign m_valid = valid_r;
  assign m_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (s_ready) begin
      valid_nxt = s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item_r <= s_item;
    end
  end

  // a held beat is never dropped without being taken
  `PDC_ASSERT_NEXT(a_hold_beat, valid_r && !m_take, valid_r, "in_stage: beat lost")

endmodule

// ===== rtl/core/pdc_parser.sv =====
// ---------------------------------------------------------------------------
// pdc_parser
// Frame parser: sync hunt, header capture, length check, CRC check, tick timeout.
// ---------------------------------------------------------------------------
module pdc_parser
  import pdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

`include "packet_deframer_crc16_assert.svh"

  phase_t      phase_r, phase_nxt;
  logic        sub_r, sub_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [7:0]  rw_r, rw_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  kind_t       kind;
  logic [7:0]  data_out;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] crc_b;
    logic [15:0] left_dec;
    b         = item.rx_byte;
    crc_b     = crc_step(crc_r, b);
    left_dec  = left_r - 16'd1;
    phase_nxt    = phase_r;
    sub_nxt      = sub_r;
    in_frame_nxt = in_frame_r;
    tick_nxt     = tick_r;
    rw_nxt       = rw_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    left_nxt     = left_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    res_valid    = 1'b0;
    kind         = K_DATA;
    data_out     = 8'h00;

    if (item.req_type) begin
      if (!in_frame_r) begin
        tick_nxt = 8'h00;
      end else if (tick_r > cfg.rx_timeout) begin
        tick_nxt     = 8'h00;
        phase_nxt    = PH_HUNT;
        sub_nxt      = 1'b0;
        in_frame_nxt = 1'b0;
        res_valid    = 1'b1;
        kind         = K_TIME;
      end else if (tick_r != TICK_MAX) begin
        tick_nxt = tick_r + 8'd1;
      end
    end else begin
      case (phase_r)
        PH_HUNT: begin
          if (sub_r) begin
            sub_nxt = 1'b0;
            if (b == SYNC_B) begin
              in_frame_nxt = 1'b1;
              tick_nxt     = 8'h00;
              rw_nxt       = 8'h00;
              cmd_nxt      = 16'h0000;
              len_nxt      = 16'h0000;
              left_nxt     = 16'h0000;
              crc_lo_nxt   = 8'h00;
              crc_nxt      = CRC_SYNC;
              phase_nxt    = PH_RW;
            end
          end else if (b == SYNC_A) begin
            sub_nxt = 1'b1;
          end
        end
        PH_RW: begin
          if (b == cfg.read_code || b == cfg.write_code) begin
            rw_nxt    = b;
            crc_nxt   = crc_b;
            sub_nxt   = 1'b0;
            phase_nxt = PH_CMD;
          end else begin
            phase_nxt    = PH_HUNT;
            sub_nxt      = 1'b0;
            in_frame_nxt = 1'b0;
          end
        end
        PH_CMD: begin
          crc_nxt = crc_b;
          if (!sub_r) begin
            cmd_nxt = {8'h00, b};
            sub_nxt = 1'b1;
          end else begin
            cmd_nxt   = {b, cmd_r[7:0]};
            sub_nxt   = 1'b0;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          crc_nxt = crc_b;
          if (!sub_r) begin
            len_nxt = {8'h00, b};
            sub_nxt = 1'b1;
          end else begin
            len_nxt = {b, len_r[7:0]};
            sub_nxt = 1'b0;
            if (len_nxt >= cfg.length_limit) begin
              phase_nxt    = PH_HUNT;
              in_frame_nxt = 1'b0;
              res_valid    = 1'b1;
              kind         = K_LEN;
            end else begin
              left_nxt  = len_nxt;
              phase_nxt = (len_nxt == 16'h0000) ? PH_CRC : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          crc_nxt  = crc_b;
          left_nxt = left_dec;
          if (left_dec == 16'h0000) begin
            phase_nxt = PH_CRC;
            sub_nxt   = 1'b0;
          end
          res_valid = 1'b1;
          kind      = K_DATA;
          data_out  = b;
        end
        PH_CRC: begin
          if (!sub_r) begin
            crc_lo_nxt = b;
            sub_nxt    = 1'b1;
          end else begin
            tick_nxt     = 8'h00;
            phase_nxt    = PH_HUNT;
            sub_nxt      = 1'b0;
            in_frame_nxt = 1'b0;
            res_valid    = 1'b1;
            kind         = ({b, crc_lo_r} == crc_r) ? K_GOOD : K_BAD;
          end
        end
        default: begin
          phase_nxt    = PH_HUNT;
          sub_nxt      = 1'b0;
          in_frame_nxt = 1'b0;
        end
      endcase
    end
  end

  // header fields are sampled after this beat's update
  assign res.kind      = kind;
  assign res.rw_flag   = rw_nxt;
  assign res.command   = cmd_nxt;
  assign res.length    = len_nxt;
  assign res.data_byte = data_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      sub_r      <= 1'b0;
      in_frame_r <= 1'b0;
      tick_r     <= 8'h00;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      sub_r      <= sub_nxt;
      in_frame_r <= in_frame_nxt;
      tick_r     <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rw_r     <= rw_nxt;
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  `PDC_ASSERT_NOW(a_frame_flag, in_frame_r, phase_r != PH_HUNT, "parser: open frame in hunt")
  `PDC_ASSERT_NOW(a_data_phase, res_valid && kind == K_DATA, phase_r == PH_DATA,
                  "parser: payload beat outside payload phase")
  `PDC_ASSERT_NEXT(a_end_hunt, fire && res_valid && (kind == K_GOOD || kind == K_BAD),
                   phase_r == PH_HUNT && tick_r == 8'h00 && !in_frame_r,
                   "parser: frame end did not return to hunt")

endmodule
